@@ design/msar_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msar_pkg
// Shared constants, opcode/funct codes and types for the MIPS subset
// execute block with its 16-bit register file.
// ----------------------------------------------------------------------------
package msar_pkg;

    localparam int NUM_REGS  = 32;
    localparam int REG_AW    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int INSTR_W   = 32;
    localparam int IDX_W     = 5;
    localparam int DATA_W    = 16;
    localparam int OPC_W     = 6;
    localparam int FUNCT_W   = 6;
    localparam int SHAMT_W   = 5;

    // Opcodes
    localparam logic [OPC_W-1:0] OPC_RTYPE = 6'h00;
    localparam logic [OPC_W-1:0] OPC_ADDI  = 6'h08;
    localparam logic [OPC_W-1:0] OPC_ANDI  = 6'h0C;
    localparam logic [OPC_W-1:0] OPC_ORI   = 6'h0D;

    // R-type function codes
    localparam logic [FUNCT_W-1:0] FN_SLL = 6'h00;
    localparam logic [FUNCT_W-1:0] FN_SRA = 6'h03;
    localparam logic [FUNCT_W-1:0] FN_ADD = 6'h20;
    localparam logic [FUNCT_W-1:0] FN_SUB = 6'h22;
    localparam logic [FUNCT_W-1:0] FN_AND = 6'h24;
    localparam logic [FUNCT_W-1:0] FN_OR  = 6'h25;
    localparam logic [FUNCT_W-1:0] FN_NOR = 6'h27;

    // Register write request from the execute logic
    typedef struct packed {
        logic              wrote;
        logic [IDX_W-1:0]  dest_index;
        logic [DATA_W-1:0] dest_value;
    } exec_res_t;

    // True when a 5-bit register index names a register that exists
    function automatic logic idx_in_range(input logic [IDX_W-1:0] idx);
        return ({1'b0, idx} < (IDX_W + 1)'(NUM_REGS));
    endfunction

endpackage

@@ design/msar_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msar_instr_if / msar_result_if
// Valid/ready channels for instruction requests and write-back results.
// ----------------------------------------------------------------------------
interface msar_instr_if
    import msar_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [INSTR_W-1:0] instruction_word;

    modport source (output valid, output instruction_word, input ready);
    modport sink   (input valid, input instruction_word, output ready);
endinterface

interface msar_result_if
    import msar_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              wrote;
    logic [IDX_W-1:0]  dest_index;
    logic [DATA_W-1:0] dest_value;

    modport source (output valid, output wrote, output dest_index, output dest_value,
                    input ready);
    modport sink   (input valid, input wrote, input dest_index, input dest_value,
                    output ready);
endinterface

@@ design/mips_subset_alu_regfile.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_subset_alu_regfile
// Executes a MIPS R/I-type subset against 32 sixteen-bit registers.
// ----------------------------------------------------------------------------
// Usage:
//   instr  - sink channel, one 32-bit instruction word per request.
//   result - source channel, one write-back report per instruction:
//            wrote, dest_index, dest_value (all zero for an unknown code).
// Pipeline: an accepted instruction is held in an operand stage with its
//   rs/rt values read from the register file; when that stage advances, the
//   ALU result is written back and loaded into the result register, which
//   drives result.valid.
// Throughput: one instruction per cycle while result.ready is high. A result
//   written at the same edge an instruction is accepted is forwarded into its
//   operands, so dependent back-to-back instructions see the new value.
// Stalls: with result.ready low the result register holds; one more
//   instruction is accepted and parked in the operand stage, then
//   instr.ready drops until the result is taken.
// Reset (rst_n, async, active low): empties both stages; every register
//   reads as zero until it is written. No clearing pass is needed.
// ----------------------------------------------------------------------------
module mips_subset_alu_regfile
    import msar_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    msar_instr_if.sink      instr,
    msar_result_if.source   result
);

    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic [INSTR_W-1:0] s1_instr_reg;
    logic               res_valid_reg;
    logic               res_valid_next;
    exec_res_t          res_reg;

    logic               accept;
    logic               adv;
    logic [DATA_W-1:0]  op_a;
    logic [DATA_W-1:0]  op_b;
    exec_res_t          exec_res;

    // Operand stage moves on when the result register is free or draining
    assign adv    = s1_valid_reg && (!res_valid_reg || result.ready);
    assign accept = instr.valid && instr.ready;
    assign instr.ready = !s1_valid_reg || adv;

    assign s1_valid_next  = accept ? 1'b1 : (adv ? 1'b0 : s1_valid_reg);
    assign res_valid_next = adv ? 1'b1 : (result.ready ? 1'b0 : res_valid_reg);

    msar_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rs_idx  (instr.instruction_word[25:21]),
        .rt_idx  (instr.instruction_word[20:16]),
        .wr_en   (adv && exec_res.wrote),
        .wr_idx  (exec_res.dest_index),
        .wr_data (exec_res.dest_value),
        .rs_data (op_a),
        .rt_data (op_b)
    );

    msar_exec u_exec (
        .instr (s1_instr_reg),
        .a     (op_a),
        .b     (op_b),
        .res   (exec_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_instr_reg <= instr.instruction_word;
        end
        if (adv)
        begin
            res_reg <= exec_res;
        end
    end

    assign result.valid      = res_valid_reg;
    assign result.wrote      = res_reg.wrote;
    assign result.dest_index = res_reg.dest_index;
    assign result.dest_value = res_reg.dest_value;

    // A request entering the operand stage is always there the next cycle
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted instruction did not reach operand stage");

    // Execution always lands in the result register
    a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> res_valid_reg)
        else $error("executed instruction produced no result");

    // A blocked operand stage keeps its instruction
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !adv) |=> (s1_valid_reg && $stable(s1_instr_reg)))
        else $error("stalled instruction lost or changed");

    // A no-write result carries zero index and value
    a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_reg.wrote) |->
            (res_reg.dest_index == '0 && res_reg.dest_value == '0))
        else $error("no-write result with nonzero payload");

    // Never accept while both stages are full and the output is stalled
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && res_valid_reg && !result.ready) |-> !instr.ready)
        else $error("pipeline overrun");

endmodule

@@ design/msar_regfile.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msar_regfile
// 16-bit register file, one write port and two registered read ports.
// Per-entry valid bits make every register read as zero after reset.
// A write in the same cycle as a read of that entry is forwarded.
// ----------------------------------------------------------------------------
module msar_regfile
    import msar_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rs_idx,
    input  logic [IDX_W-1:0]  rt_idx,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_idx,
    input  logic [DATA_W-1:0] wr_data,
    output logic [DATA_W-1:0] rs_data,
    output logic [DATA_W-1:0] rt_data
);

    logic [DATA_W-1:0] mem [NUM_REGS];
    logic [NUM_REGS-1:0] vld_reg;
    logic [DATA_W-1:0] rs_data_reg;
    logic [DATA_W-1:0] rt_data_reg;
    logic              wr_ok;
    logic              rs_fwd;
    logic              rt_fwd;
    logic              rs_hit;
    logic              rt_hit;

    assign wr_ok  = wr_en && idx_in_range(wr_idx);
    assign rs_fwd = wr_ok && (wr_idx == rs_idx);
    assign rt_fwd = wr_ok && (wr_idx == rt_idx);
    assign rs_hit = idx_in_range(rs_idx) && vld_reg[rs_idx[REG_AW-1:0]];
    assign rt_hit = idx_in_range(rt_idx) && vld_reg[rt_idx[REG_AW-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_ok)
        begin
            vld_reg[wr_idx[REG_AW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem[wr_idx[REG_AW-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            rs_data_reg <= rs_fwd ? wr_data :
                           (rs_hit ? mem[rs_idx[REG_AW-1:0]] : '0);
            rt_data_reg <= rt_fwd ? wr_data :
                           (rt_hit ? mem[rt_idx[REG_AW-1:0]] : '0);
        end
    end

    assign rs_data = rs_data_reg;
    assign rt_data = rt_data_reg;

endmodule

@@ design/msar_exec.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msar_exec
// Decode and ALU: turns an instruction and its two operands into a
// register write request.
// ----------------------------------------------------------------------------
module msar_exec
    import msar_pkg::*;
(
    input  logic [INSTR_W-1:0] instr,
    input  logic [DATA_W-1:0]  a,
    input  logic [DATA_W-1:0]  b,
    output exec_res_t          res
);

    logic [OPC_W-1:0]   opc;
    logic [IDX_W-1:0]   rt;
    logic [IDX_W-1:0]   rd;
    logic [SHAMT_W-1:0] shamt;
    logic [FUNCT_W-1:0] funct;
    logic [DATA_W-1:0]  imm;
    logic [3:0]         sra_sh;
    logic [DATA_W-1:0]  val;
    logic [IDX_W-1:0]   dst;
    logic               ok;

    assign opc   = instr[31:26];
    assign rt    = instr[20:16];
    assign rd    = instr[15:11];
    assign shamt = instr[10:6];
    assign funct = instr[5:0];
    assign imm   = instr[15:0];

    // sra saturates at 15: beyond that every bit is the sign
    assign sra_sh = shamt[4] ? 4'hF : shamt[3:0];

    always_comb
    begin
        val = '0;
        ok  = 1'b1;
        dst = rt;
        if (opc == OPC_RTYPE)
        begin
            dst = rd;
            case (funct)
                FN_SLL:  val = shamt[4] ? '0 : (b << shamt[3:0]);
                FN_SRA:  val = DATA_W'($signed(b) >>> sra_sh);
                FN_ADD:  val = a + b;
                FN_SUB:  val = a - b;
                FN_AND:  val = a & b;
                FN_OR:   val = a | b;
                FN_NOR:  val = ~(a | b);
                default: ok = 1'b0;
            endcase
        end
        else
        begin
            case (opc)
                OPC_ADDI: val = a + imm;
                OPC_ANDI: val = a & imm;
                OPC_ORI:  val = a | imm;
                default:  ok = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        if (ok && idx_in_range(dst))
        begin
            res.wrote      = 1'b1;
            res.dest_index = dst;
            res.dest_value = val;
        end
        else
        begin
            res = '0;
        end
    end

endmodule
